[rtl/core/umrt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrt_pkg
// Shared types and constants for the usable memory region table.
// ----------------------------------------------------------------------------
package umrt_pkg;

  localparam int ADDR_W      = 64;
  localparam int TYPE_W      = 8;
  localparam int COUNT_OUT_W = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_START = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USABLE_TYPE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECLAIM_TYPE = 8'd3;

  localparam logic [TYPE_W-1:0] RECLAIM_TYPE_RESET = 8'd5;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] end_addr;
    logic              a_valid;
    logic [ADDR_W-1:0] a_len;
    logic [ADDR_W-1:0] a_end;
    logic              b_valid;
    logic [ADDR_W-1:0] b_base;
    logic [ADDR_W-1:0] b_len;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } range_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_ADD_A,
    S_ADD_B,
    S_QUERY,
    S_FIN
  } back_state_t;

endpackage
`default_nettype wire

[rtl/core/usable_memory_region_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// usable_memory_region_table
// Table of usable physical memory ranges built from memory-map entries, with
// range containment queries.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. The front takes a beat per
// cycle into a one-deep hold stage, unless a full queue stalls it, and
// classifies it into a command in the next cycle; a two-entry queue feeds the
// back, which runs one command at a time: a clear runs S_CLEAR, an add
// S_ADD_A and S_ADD_B (S_ADD_A alone on a full table), a query walks the
// table memory at one entry per read-port cycle (it stops early on a hit),
// and each command ends in S_FIN. Table entries are not cleared after reset;
// only written entries are ever read, so the block is ready straight out of
// reset. Write configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module usable_memory_region_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [1:0]                         operation,
  input  wire logic [umrt_pkg::ADDR_W-1:0]        address,
  input  wire logic [umrt_pkg::ADDR_W-1:0]        size_bytes,
  input  wire logic [umrt_pkg::TYPE_W-1:0]        region_type,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic                                    query_hit,
  output logic [umrt_pkg::ADDR_W-1:0]             total_bytes,
  output logic [umrt_pkg::ADDR_W-1:0]             usable_bytes,
  output logic [umrt_pkg::ADDR_W-1:0]             highest_address,
  output logic [umrt_pkg::COUNT_OUT_W-1:0]        stored_count,
  output logic                                    overflow_flag,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [umrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [umrt_pkg::ADDR_W-1:0]        cfg_data
);

  logic           fq_push;
  umrt_pkg::cmd_t fq_wdata;
  logic           fq_full;
  logic           bq_pop;
  umrt_pkg::cmd_t bq_rdata;
  logic           bq_empty;

  umrt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .address     (address),
    .size_bytes  (size_bytes),
    .region_type (region_type),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_push      (fq_push),
    .q_data      (fq_wdata),
    .q_full      (fq_full)
  );

  umrt_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (fq_push),
    .q_wdata (fq_wdata),
    .q_full  (fq_full),
    .q_pop   (bq_pop),
    .q_rdata (bq_rdata),
    .q_empty (bq_empty)
  );

  umrt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_rdata         (bq_rdata),
    .q_empty         (bq_empty),
    .q_pop           (bq_pop),
    .empty           (empty),
    .pop             (pop),
    .query_hit       (query_hit),
    .total_bytes     (total_bytes),
    .usable_bytes    (usable_bytes),
    .highest_address (highest_address),
    .stored_count    (stored_count),
    .overflow_flag   (overflow_flag)
  );

endmodule
`default_nettype wire

[rtl/core/umrt_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrt_front
// Accepts input beats, holds the configuration and classifies each item into
// a command: a clear, pieces kept around the kernel window, or a query range.
// ----------------------------------------------------------------------------
module umrt_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic [1:0]                            operation,
  input  wire logic [umrt_pkg::ADDR_W-1:0]           address,
  input  wire logic [umrt_pkg::ADDR_W-1:0]           size_bytes,
  input  wire logic [umrt_pkg::TYPE_W-1:0]           region_type,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [umrt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [umrt_pkg::ADDR_W-1:0]           cfg_data,
  output logic                                       q_push,
  output umrt_pkg::cmd_t                             q_data,
  input  wire logic                                  q_full
);

  logic [umrt_pkg::ADDR_W-1:0] kernel_start;
  logic [umrt_pkg::ADDR_W-1:0] kernel_end;
  logic [umrt_pkg::TYPE_W-1:0] usable_type_code;
  logic [umrt_pkg::TYPE_W-1:0] reclaimable_type_code;

  logic                        s1_valid;
  umrt_pkg::op_t               s1_op;
  logic [umrt_pkg::ADDR_W-1:0] s1_addr;
  logic [umrt_pkg::ADDR_W-1:0] s1_size;
  logic [umrt_pkg::ADDR_W-1:0] s1_end;
  logic [umrt_pkg::TYPE_W-1:0] s1_type;

  logic accept;
  logic kept;
  logic overlap;
  logic is_add;

  assign cfg_ready = 1'b1;
  assign full      = s1_valid && q_full;
  assign accept    = push && !full;
  assign q_push    = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_start          <= '0;
      kernel_end            <= '0;
      usable_type_code      <= '0;
      reclaimable_type_code <= umrt_pkg::RECLAIM_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        umrt_pkg::REG_KERNEL_START: kernel_start          <= cfg_data;
        umrt_pkg::REG_KERNEL_END:   kernel_end            <= cfg_data;
        umrt_pkg::REG_USABLE_TYPE:  usable_type_code      <= cfg_data[umrt_pkg::TYPE_W-1:0];
        umrt_pkg::REG_RECLAIM_TYPE: reclaimable_type_code <= cfg_data[umrt_pkg::TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= umrt_pkg::op_t'(operation);
      s1_addr <= address;
      s1_size <= size_bytes;
      s1_end  <= address + size_bytes;
      s1_type <= region_type;
    end
  end

  always_comb begin
    is_add  = (s1_op == umrt_pkg::OP_ADD);
    kept    = (s1_type == usable_type_code) || (s1_type == reclaimable_type_code);
    overlap = (s1_addr < kernel_end) && (kernel_start < s1_end);

    q_data          = '0;
    q_data.op       = s1_op;
    q_data.addr     = s1_addr;
    q_data.size     = s1_size;
    q_data.end_addr = s1_end;
    q_data.a_valid  = is_add && kept && (!overlap || (s1_addr < kernel_start));
    q_data.a_len    = overlap ? (kernel_start - s1_addr) : s1_size;
    q_data.a_end    = overlap ? kernel_start : s1_end;
    q_data.b_valid  = is_add && kept && overlap && (kernel_end < s1_end);
    q_data.b_base   = kernel_end;
    q_data.b_len    = s1_end - kernel_end;
  end

endmodule
`default_nettype wire

[rtl/core/umrt_cmd_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrt_cmd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module umrt_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_push,
  input  wire umrt_pkg::cmd_t q_wdata,
  output logic                q_full,
  input  wire logic           q_pop,
  output umrt_pkg::cmd_t      q_rdata,
  output logic                q_empty
);

  localparam int PTR_W = $clog2(umrt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(umrt_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(umrt_pkg::QUEUE_DEPTH - 1);

  umrt_pkg::cmd_t   slots [umrt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_full  = (fill == CNT_W'(umrt_pkg::QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign q_rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (q_push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (q_pop && !q_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wr_ptr] <= q_wdata;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(q_pop && q_empty))
    else $error("command popped from an empty queue");
`endif

endmodule
`default_nettype wire

[rtl/core/umrt_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrt_back
// Carries out commands: clears the map, stores ranges in the table memory,
// keeps the running sums and walks the table for queries. Holds the result
// register.
// ----------------------------------------------------------------------------
module umrt_back #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire umrt_pkg::cmd_t                     q_rdata,
  input  wire logic                               q_empty,
  output logic                                    q_pop,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic                                    query_hit,
  output logic [umrt_pkg::ADDR_W-1:0]             total_bytes,
  output logic [umrt_pkg::ADDR_W-1:0]             usable_bytes,
  output logic [umrt_pkg::ADDR_W-1:0]             highest_address,
  output logic [umrt_pkg::COUNT_OUT_W-1:0]        stored_count,
  output logic                                    overflow_flag
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  umrt_pkg::range_t            mem [TABLE_DEPTH];
  umrt_pkg::range_t            rd_data;

  umrt_pkg::back_state_t       state, state_next;
  umrt_pkg::cmd_t              cmd, cmd_next;
  logic [CW-1:0]               count, count_next;
  logic [umrt_pkg::ADDR_W-1:0] total, total_next;
  logic [umrt_pkg::ADDR_W-1:0] usable, usable_next;
  logic [umrt_pkg::ADDR_W-1:0] top, top_next;
  logic                        hit, hit_next;
  logic                        flag, flag_next;
  logic [CW-1:0]               rd_idx, rd_idx_next;
  logic                        pend, pend_next;
  logic                        res_valid;

  logic                        mem_we;
  logic                        mem_re;
  umrt_pkg::range_t            wr_data;
  logic                        res_load;
  logic                        match;

  assign empty = !res_valid;
  assign match = (rd_data.start <= cmd.addr)
              && (cmd.end_addr <= (rd_data.start + rd_data.len));

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    count_next  = count;
    total_next  = total;
    usable_next = usable;
    top_next    = top;
    hit_next    = hit;
    flag_next   = flag;
    rd_idx_next = rd_idx;
    pend_next   = pend;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_data     = '0;
    q_pop       = 1'b0;
    res_load    = 1'b0;

    unique case (state)
      umrt_pkg::S_IDLE: begin
        if (!q_empty && (!res_valid || pop)) begin
          q_pop       = 1'b1;
          cmd_next    = q_rdata;
          hit_next    = 1'b0;
          flag_next   = 1'b0;
          rd_idx_next = '0;
          pend_next   = 1'b0;
          unique case (q_rdata.op)
            umrt_pkg::OP_CLEAR: state_next = umrt_pkg::S_CLEAR;
            umrt_pkg::OP_ADD:   state_next = umrt_pkg::S_ADD_A;
            umrt_pkg::OP_QUERY: state_next = umrt_pkg::S_QUERY;
            default:            state_next = umrt_pkg::S_FIN;
          endcase
        end
      end
      umrt_pkg::S_CLEAR: begin
        count_next  = '0;
        total_next  = '0;
        usable_next = '0;
        top_next    = '0;
        state_next  = umrt_pkg::S_FIN;
      end
      umrt_pkg::S_ADD_A: begin
        if (count == DEPTH_C) begin
          flag_next  = 1'b1;
          state_next = umrt_pkg::S_FIN;
        end else begin
          total_next = total + cmd.size;
          if (cmd.a_valid) begin
            mem_we        = 1'b1;
            wr_data.start = cmd.addr;
            wr_data.len   = cmd.a_len;
            count_next    = count + 1'b1;
            usable_next   = usable + cmd.a_len;
            if (cmd.a_end > top) begin
              top_next = cmd.a_end;
            end
          end
          state_next = umrt_pkg::S_ADD_B;
        end
      end
      umrt_pkg::S_ADD_B: begin
        if (cmd.b_valid) begin
          if (count == DEPTH_C) begin
            flag_next = 1'b1;
          end else begin
            mem_we        = 1'b1;
            wr_data.start = cmd.b_base;
            wr_data.len   = cmd.b_len;
            count_next    = count + 1'b1;
            usable_next   = usable + cmd.b_len;
            if (cmd.end_addr > top) begin
              top_next = cmd.end_addr;
            end
          end
        end
        state_next = umrt_pkg::S_FIN;
      end
      umrt_pkg::S_QUERY: begin
        if (pend && match) begin
          hit_next   = 1'b1;
          state_next = umrt_pkg::S_FIN;
        end else if (rd_idx < count) begin
          mem_re      = 1'b1;
          rd_idx_next = rd_idx + 1'b1;
          pend_next   = 1'b1;
        end else begin
          state_next = umrt_pkg::S_FIN;
        end
      end
      umrt_pkg::S_FIN: begin
        res_load   = 1'b1;
        state_next = umrt_pkg::S_IDLE;
      end
      default: state_next = umrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= umrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      usable    <= '0;
      top       <= '0;
      hit       <= 1'b0;
      flag      <= 1'b0;
      rd_idx    <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      count  <= count_next;
      total  <= total_next;
      usable <= usable_next;
      top    <= top_next;
      hit    <= hit_next;
      flag   <= flag_next;
      rd_idx <= rd_idx_next;
      pend   <= pend_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      query_hit       <= hit;
      total_bytes     <= total;
      usable_bytes    <= usable;
      highest_address <= top;
      stored_count    <= umrt_pkg::COUNT_OUT_W'(count);
      overflow_flag   <= flag;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("stored range count beyond table depth");
  a_res_free: assert property (@(posedge clk) disable iff (rst) res_load |-> (!res_valid || pop))
    else $error("result register overwritten before it was taken");
  a_flag_add: assert property (@(posedge clk) disable iff (rst)
      (res_load && flag) |-> (cmd.op == umrt_pkg::OP_ADD))
    else $error("overflow flagged on a non-add command");
  a_hit_query: assert property (@(posedge clk) disable iff (rst)
      (res_load && hit) |-> (cmd.op == umrt_pkg::OP_QUERY))
    else $error("hit reported on a non-query command");
`endif

endmodule
`default_nettype wire

[verif/region_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_table_checker
// Watches the entry, result and register channels of the usable memory region
// table. Keeps its own copy of the range table, sums and window settings,
// works out the result of every accepted entry beat and compares each result
// beat, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module region_table_checker #(
  parameter int DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               full,
  input  logic [1:0]                         operation,
  input  logic [umrt_pkg::ADDR_W-1:0]        address,
  input  logic [umrt_pkg::ADDR_W-1:0]        size_bytes,
  input  logic [umrt_pkg::TYPE_W-1:0]        region_type,
  input  logic                               empty,
  input  logic                               pop,
  input  logic                               query_hit,
  input  logic [umrt_pkg::ADDR_W-1:0]        total_bytes,
  input  logic [umrt_pkg::ADDR_W-1:0]        usable_bytes,
  input  logic [umrt_pkg::ADDR_W-1:0]        highest_address,
  input  logic [umrt_pkg::COUNT_OUT_W-1:0]   stored_count,
  input  logic                               overflow_flag,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [umrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [umrt_pkg::ADDR_W-1:0]        cfg_data,
  output int                                 errors,
  output int                                 outstanding,
  output int                                 beats_checked,
  output int                                 hits_seen,
  output int                                 flags_seen
);
  import umrt_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [63:0] total;
    logic [63:0] usable;
    logic [63:0] top;
    logic [7:0]  count;
    logic        flag;
  } region_result_t;

  region_result_t expected_q[$];

  logic [63:0] span_base [DEPTH];
  logic [63:0] span_len  [DEPTH];
  int          held;
  logic [63:0] total_sum;
  logic [63:0] usable_sum;
  logic [63:0] top_end;
  logic [63:0] win_start;
  logic [63:0] win_end;
  logic [7:0]  usable_code;
  logic [7:0]  reclaim_code;

  task automatic store_span(input logic [63:0] base, input logic [63:0] len,
                            output logic ok);
    logic [63:0] span_end;
    span_end = base + len;
    ok = 1'b0;
    if (held < DEPTH) begin
      span_base[held] = base;
      span_len[held]  = len;
      held++;
      usable_sum += len;
      if (span_end > top_end) top_end = span_end;
      ok = 1'b1;
    end
  endtask

  task automatic add_region(input logic [63:0] base, input logic [63:0] len,
                            input logic [7:0] kind, output logic dropped);
    logic [63:0] region_end;
    logic        ok;
    logic        piece_ok;
    region_end = base + len;
    ok = 1'b1;
    if (held >= DEPTH) begin
      ok = 1'b0;
    end else begin
      total_sum += len;
      if (kind == usable_code || kind == reclaim_code) begin
        if (base < win_end && win_start < region_end) begin
          // carve the kernel window out, keeping what lies either side
          if (base < win_start) begin
            store_span(base, win_start - base, piece_ok);
            ok &= piece_ok;
          end
          if (win_end < region_end) begin
            store_span(win_end, region_end - win_end, piece_ok);
            ok &= piece_ok;
          end
        end else begin
          store_span(base, len, ok);
        end
      end
    end
    dropped = !ok;
  endtask

  function automatic logic range_held(input logic [63:0] addr, input logic [63:0] len);
    logic [63:0] q_end;
    logic [63:0] s_end;
    range_held = 1'b0;
    q_end = addr + len;
    for (int i = 0; i < held; i++) begin
      s_end = span_base[i] + span_len[i];
      if (span_base[i] <= addr && q_end <= s_end) range_held = 1'b1;
    end
  endfunction

  task automatic predict(input op_t op, input logic [63:0] addr, input logic [63:0] len,
                         input logic [7:0] kind, output region_result_t res);
    logic hit;
    logic flag;
    hit  = 1'b0;
    flag = 1'b0;
    case (op)
      OP_CLEAR: begin
        held       = 0;
        total_sum  = '0;
        usable_sum = '0;
        top_end    = '0;
      end
      OP_ADD:   add_region(addr, len, kind, flag);
      OP_QUERY: hit = range_held(addr, len);
      default: ;
    endcase
    res.hit    = hit;
    res.total  = total_sum;
    res.usable = usable_sum;
    res.top    = top_end;
    res.count  = 8'(held);
    res.flag   = flag;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    region_result_t want;
    if (rst) begin
      held         = 0;
      total_sum    = '0;
      usable_sum   = '0;
      top_end      = '0;
      win_start    = '0;
      win_end      = '0;
      usable_code  = '0;
      reclaim_code = RECLAIM_TYPE_RESET;
      expected_q.delete();
      outstanding  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_START: win_start    = cfg_data;
          REG_KERNEL_END:   win_end      = cfg_data;
          REG_USABLE_TYPE:  usable_code  = cfg_data[7:0];
          REG_RECLAIM_TYPE: reclaim_code = cfg_data[7:0];
          default: ;
        endcase
      end
      // result side first: a beat leaving now can never belong to an entry arriving now
      if (pop && !empty) begin
        beats_checked++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, expected nothing, got total %h count %h",
                   $time, total_bytes, stored_count);
        end else begin
          want = expected_q.pop_front();
          check_field("query_hit", want.hit, query_hit);
          check_field("total_bytes", want.total, total_bytes);
          check_field("usable_bytes", want.usable, usable_bytes);
          check_field("highest_address", want.top, highest_address);
          check_field("stored_count", want.count, stored_count);
          check_field("overflow_flag", want.flag, overflow_flag);
        end
        if (query_hit === 1'b1) hits_seen++;
        if (overflow_flag === 1'b1) flags_seen++;
      end
      if (push && !full) begin
        predict(op_t'(operation), address, size_bytes, region_type, want);
        expected_q.push_back(want);
      end
      outstanding = expected_q.size();
    end
  end

endmodule

[verif/usable_memory_region_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usable_memory_region_table_tb
// Drives memory-map entries, clears and range queries into the region table
// under eight window and type-code settings and four idling patterns. A short
// directed opening covers the edge cases; the rest is mostly well-formed maps
// with random content, table fills with a split landing on the last free slot,
// and random noise. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module usable_memory_region_table_tb;
  import umrt_pkg::*;

  localparam int          DEPTH           = 128;
  localparam int          ITEMS_PER_PHASE = 165;
  localparam int          CYCLE_LIMIT     = 1_000_000;
  localparam logic [63:0] ALL_ONES        = '1;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic [1:0]  operation   = '0;
  logic [63:0] address     = '0;
  logic [63:0] size_bytes  = '0;
  logic [7:0]  region_type = '0;
  logic        pop         = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [7:0]  cfg_index   = '0;
  logic [63:0] cfg_data    = '0;

  logic        full;
  logic        empty;
  logic        query_hit;
  logic [63:0] total_bytes;
  logic [63:0] usable_bytes;
  logic [63:0] highest_address;
  logic [7:0]  stored_count;
  logic        overflow_flag;
  logic        cfg_ready;

  int errors;
  int outstanding;
  int beats_checked;
  int hits_seen;
  int flags_seen;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int items_sent    = 0;
  int cycles        = 0;

  logic [63:0] win_start    = '0;
  logic [63:0] win_end      = '0;
  logic [7:0]  usable_code  = '0;
  logic [7:0]  reclaim_code = RECLAIM_TYPE_RESET;
  logic [63:0] map_base[$];
  logic [63:0] map_len[$];

  always #5 clk = ~clk;

  usable_memory_region_table #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .operation(operation), .address(address), .size_bytes(size_bytes),
    .region_type(region_type),
    .empty(empty), .pop(pop),
    .query_hit(query_hit), .total_bytes(total_bytes), .usable_bytes(usable_bytes),
    .highest_address(highest_address), .stored_count(stored_count),
    .overflow_flag(overflow_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  region_table_checker #(.DEPTH(DEPTH)) u_check (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .operation(operation), .address(address), .size_bytes(size_bytes),
    .region_type(region_type),
    .empty(empty), .pop(pop),
    .query_hit(query_hit), .total_bytes(total_bytes), .usable_bytes(usable_bytes),
    .highest_address(highest_address), .stored_count(stored_count),
    .overflow_flag(overflow_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .beats_checked(beats_checked),
    .hits_seen(hits_seen), .flags_seen(flags_seen)
  );

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(9))
      0:       return rand64();
      1:       return ALL_ONES - $urandom_range(4095);
      2:       return win_start + $urandom_range(8191) - 64'd4096;
      3:       return win_end + $urandom_range(8191) - 64'd4096;
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_len();
    case ($urandom_range(11))
      0:       return rand64();
      1:       return 64'd0;
      2:       return ALL_ONES - $urandom_range(255);
      3:       return 64'd1;
      4, 5:    return {32'd0, $urandom};
      default: return 64'($urandom_range(1, 32'h0010_0000));
    endcase
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(9))
      0, 1, 2, 3: return usable_code;
      4, 5, 6:    return reclaim_code;
      7:          return usable_code + 8'd1;
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic send(input op_t op, input logic [63:0] addr, input logic [63:0] len,
                      input logic [7:0] kind);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      push        <= 1'b0;
      operation   <= 2'($urandom);
      address     <= rand64();
      size_bytes  <= rand64();
      region_type <= 8'($urandom);
      @(posedge clk);
    end
    push        <= 1'b1;
    operation   <= op;
    address     <= addr;
    size_bytes  <= len;
    region_type <= kind;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    if (op == OP_CLEAR) begin
      map_base.delete();
      map_len.delete();
    end else if (op == OP_ADD && map_base.size() < 64) begin
      map_base.push_back(addr);
      map_len.push_back(len);
    end
  endtask

  // mostly sub-ranges of entries already sent, so hits are common
  task automatic send_query();
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] off;
    logic [63:0] rest;
    logic [63:0] qlen;
    int          k;
    if (map_base.size() != 0 && $urandom_range(3) != 0) begin
      k    = $urandom_range(map_base.size() - 1);
      base = map_base[k];
      len  = map_len[k];
      off  = (len == 0) ? 64'd0 : rand64() % len;
      rest = len - off;
      qlen = (rest == ALL_ONES) ? rand64() : rand64() % (rest + 64'd1);
      case ($urandom_range(3))
        0:       qlen = rest;
        1:       qlen = rest + 64'd1;
        default: ;
      endcase
      send(OP_QUERY, base + off, qlen, 8'($urandom));
    end else begin
      send(OP_QUERY, pick_addr(), pick_len(), 8'($urandom));
    end
  endtask

  task automatic map_sequence();
    send(OP_CLEAR, rand64(), rand64(), 8'($urandom));
    repeat ($urandom_range(1, 24)) begin
      if ($urandom_range(9) < 3) send_query();
      send(OP_ADD, pick_addr(), pick_len(), pick_kind());
    end
    repeat ($urandom_range(1, 6)) send_query();
  endtask

  task automatic fill_sequence();
    logic [63:0] d;
    send(OP_CLEAR, rand64(), rand64(), 8'($urandom));
    if (win_start != 0 && win_end >= win_start && win_end < 64'h4000_0000_0000_0000) begin
      for (int i = 0; i < DEPTH - 1; i++)
        send(OP_ADD, win_end + 64'(i) * 64'h1_0000 + $urandom_range(255),
             64'($urandom_range(1, 32'hFF00)), usable_code);
      // straddles the window with one slot free: the upper piece is lost
      d = (win_start > 64'd1000) ? 64'($urandom_range(1, 1000)) : win_start;
      send(OP_ADD, win_start - d, d + (win_end - win_start) + $urandom_range(1, 1000),
           reclaim_code);
    end else begin
      repeat (DEPTH + 4) send(OP_ADD, pick_addr(), pick_len(), usable_code);
    end
    repeat ($urandom_range(2, 4)) send(OP_ADD, pick_addr(), pick_len(), pick_kind());
    repeat ($urandom_range(3, 8)) send_query();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 5))
      send(op_t'(2'($urandom_range(3))), rand64(), rand64(), 8'($urandom));
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic configure(input logic [63:0] ks, input logic [63:0] ke,
                           input logic [7:0] uc, input logic [7:0] rc);
    drain();
    write_reg(REG_KERNEL_START, ks);
    write_reg(REG_KERNEL_END, ke);
    write_reg(REG_USABLE_TYPE, {56'(rand64()), uc});
    write_reg(REG_RECLAIM_TYPE, {56'(rand64()), rc});
    cfg_valid    <= 1'b0;
    win_start    = ks;
    win_end      = ke;
    usable_code  = uc;
    reclaim_code = rc;
  endtask

  task automatic directed();
    send(OP_NOP, 64'd0, 64'd0, 8'd0);
    send(OP_QUERY, 64'd0, 64'd0, 8'd0);
    send(OP_ADD, 64'd0, 64'd0, 8'd0);
    send(OP_ADD, 64'h1000, 64'h1000, 8'd5);
    send(OP_ADD, 64'h3000, 64'h1000, 8'd1);
    send(OP_ADD, ALL_ONES - 64'hFFF, 64'h2000, 8'd0);
    send(OP_ADD, ALL_ONES, ALL_ONES, 8'hFF);
    send(OP_QUERY, 64'h1000, 64'h1000, 8'd0);
    send(OP_QUERY, 64'h1800, 64'h801, 8'd0);
    send(OP_QUERY, 64'h2000, 64'd0, 8'd0);
    send(OP_QUERY, ALL_ONES, 64'd1, 8'hFF);
    send(OP_NOP, ALL_ONES, ALL_ONES, 8'hFF);
    send(OP_CLEAR, rand64(), rand64(), 8'($urandom));
    send(OP_QUERY, 64'h1000, 64'd1, 8'd0);
    configure(64'h1_0000, 64'h2_0000, 8'd0, 8'd5);
    send(OP_ADD, 64'h1_2000, 64'h1000, 8'd0);
    send(OP_ADD, 64'h8000, 64'h2_0000, 8'd0);
    send(OP_ADD, 64'hF000, 64'h2000, 8'd5);
    send(OP_ADD, 64'h1_F000, 64'h2000, 8'd0);
    send(OP_ADD, 64'h2_0000, 64'h100, 8'd0);
    send(OP_ADD, 64'hF000, 64'h1000, 8'd5);
    send(OP_ADD, ALL_ONES - 64'hF, 64'h20, 8'd0);
    send(OP_ADD, 64'h100, ALL_ONES, 8'd0);
    send(OP_QUERY, 64'h8000, 64'h8000, 8'd0);
    send(OP_QUERY, 64'hFF00, 64'h200, 8'd0);
  endtask

  initial begin
    int phase_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    directed();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(64'h0010_0000, 64'h0020_0000, 8'd1, 8'd3);
        1: configure(64'd0, ALL_ONES, 8'd0, 8'd5);
        2: configure(ALL_ONES, 64'd0, 8'hFF, 8'd0);
        3: configure(64'h8000_0000, 64'h8000_0000, 8'd7, 8'd7);
        4: configure(64'($urandom) + 64'd1, 64'($urandom) + 64'($urandom) + 64'd1,
                     8'($urandom), 8'($urandom));
        5: configure(64'h8000_0000_0000_0000, 64'hC000_0000_0000_0000, 8'd2, 8'hFF);
        6: configure(64'd1, 64'd2, 8'd0, 8'd1);
        default: configure(64'h1000, 64'h1000_0000_0000, 8'($urandom), 8'd5);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 84; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 84; end
        default: begin send_idle_pct = 25; pop_stall_pct = 25; end
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      if (p == 0 || p >= 3 && p <= 6) fill_sequence();
      while (items_sent < phase_end) begin
        case ($urandom_range(9))
          0, 1:    noise_burst();
          default: map_sequence();
        endcase
      end
    end
    drain();
    repeat (200) @(posedge clk);
    $display("%0d entry beats sent across eight window settings and four idling patterns",
             items_sent);
    $display("%0d result beats checked, %0d query hits, %0d flagged adds",
             beats_checked, hits_seen, flags_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/umrt_pkg.sv
rtl/core/umrt_front.sv
rtl/core/umrt_cmd_queue.sv
rtl/core/umrt_back.sv
rtl/core/usable_memory_region_table.sv
verif/region_table_checker.sv
verif/usable_memory_region_table_tb.sv
